FILE: design/interval_window_outlier_filter_macros.svh
// Assertion macros for the interval window outlier filter checker.
`ifndef INTERVAL_WINDOW_OUTLIER_FILTER_MACROS_SVH
`define INTERVAL_WINDOW_OUTLIER_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define IWOF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define IWOF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/iwof_pkg.sv
// Package: constants, payload and config types, sequencer states of the outlier filter.
`default_nettype none
package iwof_pkg;

  localparam int WINDOW_LENGTH = 16;
  localparam int TICK_W        = 24;
  localparam int RES_W         = 10;
  localparam int OFF_W         = 20;
  localparam int PERIOD_W      = 36;
  localparam int PROD_W        = TICK_W + RES_W;
  localparam int IDX_W         = $clog2(WINDOW_LENGTH);
  localparam int CNT_W         = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W         = TICK_W + IDX_W;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);

  localparam logic [RES_W-1:0] RES_PS_RESET = RES_W'(55);
  localparam logic [RES_W-1:0] RES_NS_RESET = RES_W'(125);

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_RES_PS = 2'd1;
  localparam logic [1:0] REG_OFF_PS = 2'd2;
  localparam logic [1:0] REG_RES_NS = 2'd3;

  localparam logic MODE_MEDIAN   = 1'b0;
  localparam logic MODE_MAJORITY = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] first_reading;
    logic [TICK_W-1:0] second_reading;
  } in_item_t;

  typedef struct packed {
    logic signed [PERIOD_W-1:0] period_value;
    logic                       count_error;
  } out_item_t;

  typedef struct packed {
    logic             mode_select;
    logic [RES_W-1:0] ps_per_tick;
    logic [OFF_W-1:0] offset_ps;
    logic [RES_W-1:0] resolution_ns;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_COUNT,
    ST_CAND,
    ST_LOAD,
    ST_RANK,
    ST_SCAN,
    ST_SELECT,
    ST_MUL,
    ST_FINISH
  } state_e;

endpackage
`default_nettype wire

FILE: design/iwof_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iwof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/iwof_engine.sv
// Window sequencer: sweeps the tick RAM through one compare/accumulate unit, then scales.
`default_nettype none
module iwof_engine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire iwof_pkg::cfg_t                     cfg_i,
  output logic      [iwof_pkg::IDX_W-1:0]         raddr_o,
  input  wire logic [iwof_pkg::TICK_W-1:0]        rdata_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output iwof_pkg::out_item_t                     result_o
);

  localparam int IDX_W  = iwof_pkg::IDX_W;
  localparam int CNT_W  = iwof_pkg::CNT_W;
  localparam int SUM_W  = iwof_pkg::SUM_W;
  localparam int TICK_W = iwof_pkg::TICK_W;
  localparam int PROD_W = iwof_pkg::PROD_W;
  localparam int PER_W  = iwof_pkg::PERIOD_W;
  localparam int RES_W_SEL = iwof_pkg::RES_W;

  iwof_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              iss_q, iss_d;
  logic              rv_q, rv_d;
  logic              rl_q, rl_d;
  logic              rf_q, rf_d;
  logic [IDX_W-1:0]  j_q, j_d;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [TICK_W-1:0] cand_q, cand_d;
  logic [CNT_W-1:0]  lt_q, lt_d;
  logic [CNT_W-1:0]  le_q, le_d;
  logic [TICK_W-1:0] val_q, val_d;
  logic [TICK_W-1:0] v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  logic [CNT_W-1:0]  c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic              has1_q, has1_d, has2_q, has2_d;
  logic              err_q, err_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic [CNT_W-1:0]  pick;
  logic [CNT_W-1:0]  kth;
  logic [CNT_W-1:0]  lt_n;
  logic [CNT_W-1:0]  le_n;
  logic [RES_W_SEL-1:0] res_sel;

  assign pick = (n_q == '0) ? '0 : n_q - CNT_W'(1);
  assign kth  = pick >> 1;
  assign lt_n = lt_q + CNT_W'(rdata_i < cand_q);
  assign le_n = le_q + CNT_W'(rdata_i <= cand_q);
  assign res_sel = (cfg_i.mode_select == iwof_pkg::MODE_MAJORITY) ?
                   cfg_i.resolution_ns : cfg_i.ps_per_tick;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    iss_d    = 1'b0;
    rv_d     = 1'b0;
    rl_d     = 1'b0;
    rf_d     = 1'b0;
    j_d      = j_q;
    sum_d    = sum_q;
    n_d      = n_q;
    cand_d   = cand_q;
    lt_d     = lt_q;
    le_d     = le_q;
    val_d    = val_q;
    v0_d     = v0_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    c0_d     = c0_q;
    c1_d     = c1_q;
    c2_d     = c2_q;
    has1_d   = has1_q;
    has2_d   = has2_q;
    err_d    = err_q;
    prod_d   = prod_q;
    raddr_o  = idx_q;
    done_o   = 1'b0;
    result_o = '0;

    // address sweep shared by all scan states
    if (iss_q) begin
      idx_d = (idx_q == iwof_pkg::LAST_IDX) ? '0 : idx_q + IDX_W'(1);
      iss_d = (idx_q != iwof_pkg::LAST_IDX);
      rv_d  = 1'b1;
      rl_d  = (idx_q == iwof_pkg::LAST_IDX);
      rf_d  = (idx_q == '0);
    end

    case (state_q)
      iwof_pkg::ST_IDLE: begin
        if (start_i) begin
          iss_d = 1'b1;
          if (cfg_i.mode_select == iwof_pkg::MODE_MAJORITY) begin
            state_d = iwof_pkg::ST_SCAN;
          end else begin
            sum_d   = '0;
            state_d = iwof_pkg::ST_SUM;
          end
        end
      end
      iwof_pkg::ST_SUM: begin
        if (rv_q) begin
          sum_d = sum_q + SUM_W'(rdata_i);
        end
        if (rl_q) begin
          n_d     = '0;
          iss_d   = 1'b1;
          state_d = iwof_pkg::ST_COUNT;
        end
      end
      iwof_pkg::ST_COUNT: begin
        if (rv_q && (SUM_W'(rdata_i) * SUM_W'(iwof_pkg::WINDOW_LENGTH) < sum_q)) begin
          n_d = n_q + CNT_W'(1);
        end
        if (rl_q) begin
          j_d     = '0;
          state_d = iwof_pkg::ST_CAND;
        end
      end
      iwof_pkg::ST_CAND: begin
        raddr_o = j_q;
        state_d = iwof_pkg::ST_LOAD;
      end
      iwof_pkg::ST_LOAD: begin
        cand_d  = rdata_i;
        lt_d    = '0;
        le_d    = '0;
        iss_d   = 1'b1;
        state_d = iwof_pkg::ST_RANK;
      end
      iwof_pkg::ST_RANK: begin
        if (rv_q) begin
          lt_d = lt_n;
          le_d = le_n;
        end
        if (rl_q) begin
          // candidate holds rank kth when kth lies in [lt, le)
          if ((lt_n <= kth) && (kth < le_n)) begin
            val_d   = cand_q;
            state_d = iwof_pkg::ST_MUL;
          end else begin
            j_d     = j_q + IDX_W'(1);
            state_d = iwof_pkg::ST_CAND;
          end
        end
      end
      iwof_pkg::ST_SCAN: begin
        if (rv_q) begin
          if (rf_q) begin
            v0_d   = rdata_i;
            c0_d   = CNT_W'(1);
            v1_d   = '0;
            c1_d   = '0;
            v2_d   = '0;
            c2_d   = '0;
            has1_d = 1'b0;
            has2_d = 1'b0;
            err_d  = 1'b0;
          end else if (rdata_i == v0_q) begin
            c0_d = c0_q + CNT_W'(1);
          end else if (!has1_q) begin
            has1_d = 1'b1;
            v1_d   = rdata_i;
            c1_d   = CNT_W'(1);
          end else if (rdata_i == v1_q) begin
            c1_d = c1_q + CNT_W'(1);
          end else if (!has2_q) begin
            has2_d = 1'b1;
            v2_d   = rdata_i;
            c2_d   = CNT_W'(1);
          end else if (rdata_i == v2_q) begin
            c2_d = c2_q + CNT_W'(1);
          end else begin
            err_d = 1'b1;
          end
        end
        if (rl_q) begin
          state_d = iwof_pkg::ST_SELECT;
        end
      end
      iwof_pkg::ST_SELECT: begin
        if (c1_q > c2_q) begin
          val_d = (c0_q > c1_q) ? v0_q : v1_q;
        end else begin
          val_d = (c0_q > c2_q) ? v0_q : v2_q;
        end
        state_d = iwof_pkg::ST_MUL;
      end
      iwof_pkg::ST_MUL: begin
        prod_d  = PROD_W'(val_q) * PROD_W'(res_sel);
        state_d = iwof_pkg::ST_FINISH;
      end
      iwof_pkg::ST_FINISH: begin
        done_o = 1'b1;
        if (cfg_i.mode_select == iwof_pkg::MODE_MAJORITY) begin
          result_o.count_error  = err_q;
          result_o.period_value = err_q ? '1 : PER_W'(prod_q);
        end else begin
          result_o.count_error  = 1'b0;
          result_o.period_value = PER_W'(prod_q) - PER_W'(cfg_i.offset_ps);
        end
        state_d = iwof_pkg::ST_IDLE;
      end
      default: begin
        state_d = iwof_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != iwof_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iwof_pkg::ST_IDLE;
      idx_q   <= '0;
      iss_q   <= 1'b0;
      rv_q    <= 1'b0;
      rl_q    <= 1'b0;
      rf_q    <= 1'b0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
      rl_q    <= rl_d;
      rf_q    <= rf_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    n_q    <= n_d;
    cand_q <= cand_d;
    lt_q   <= lt_d;
    le_q   <= le_d;
    val_q  <= val_d;
    v0_q   <= v0_d;
    v1_q   <= v1_d;
    v2_q   <= v2_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    c2_q   <= c2_d;
    has1_q <= has1_d;
    has2_q <= has2_d;
    err_q  <= err_d;
    prod_q <= prod_d;
  end

endmodule
`default_nettype wire

FILE: design/interval_window_outlier_filter.sv
// Interval window outlier filter: APB registers, tick RAM, window sequencer, result register.
// Each transfer stores |first_reading - second_reading| in a 16-entry window RAM;
// every 16th transfer closes the window and starts one filtered result.
// Mode 0 (sorted lower-cluster median, picoseconds) and mode 1 (majority of at most
// three values, nanoseconds) both sweep the window RAM through its single read port,
// one entry per cycle, with mode 0 ranking each candidate against the whole window.
// in_ready_o is low while a window is being evaluated, and also when a closing
// transfer would meet an untaken result.
// Registers (APB, byte address 4*i): mode_select, ps_per_tick, offset_ps,
// resolution_ns; write them only while the block is idle.
`default_nettype none
module interval_window_outlier_filter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire iwof_pkg::in_item_t                in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output iwof_pkg::out_item_t                    out_item_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [iwof_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [iwof_pkg::DATA_W-1:0]       pwdata,
  output logic      [iwof_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready
);

  localparam int IDX_W  = iwof_pkg::IDX_W;
  localparam int TICK_W = iwof_pkg::TICK_W;

  iwof_pkg::cfg_t      cfg_q, cfg_d;
  logic [IDX_W-1:0]    fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  iwof_pkg::out_item_t out_item_q;

  logic                in_xfer;
  logic                cfg_wr;
  logic                start;
  logic [TICK_W-1:0]   tick;
  logic [IDX_W-1:0]    raddr;
  logic [TICK_W-1:0]   rdata;
  logic                busy;
  logic                done;
  iwof_pkg::out_item_t result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        iwof_pkg::REG_MODE:   cfg_d.mode_select   = pwdata[0];
        iwof_pkg::REG_RES_PS: cfg_d.ps_per_tick   = pwdata[iwof_pkg::RES_W-1:0];
        iwof_pkg::REG_OFF_PS: cfg_d.offset_ps     = pwdata[iwof_pkg::OFF_W-1:0];
        iwof_pkg::REG_RES_NS: cfg_d.resolution_ns = pwdata[iwof_pkg::RES_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      iwof_pkg::REG_MODE:   prdata = iwof_pkg::DATA_W'(cfg_q.mode_select);
      iwof_pkg::REG_RES_PS: prdata = iwof_pkg::DATA_W'(cfg_q.ps_per_tick);
      iwof_pkg::REG_OFF_PS: prdata = iwof_pkg::DATA_W'(cfg_q.offset_ps);
      iwof_pkg::REG_RES_NS: prdata = iwof_pkg::DATA_W'(cfg_q.resolution_ns);
      default:              prdata = '0;
    endcase
  end

  assign in_ready_o = !busy && !(out_valid_q && (fill_q == iwof_pkg::LAST_IDX));
  assign in_xfer    = in_valid_i && in_ready_o;
  assign start      = in_xfer && (fill_q == iwof_pkg::LAST_IDX);
  assign tick       = (in_item_i.first_reading > in_item_i.second_reading) ?
                      (in_item_i.first_reading - in_item_i.second_reading) :
                      (in_item_i.second_reading - in_item_i.first_reading);

  always_comb begin
    fill_d = fill_q;
    if (in_xfer) begin
      fill_d = (fill_q == iwof_pkg::LAST_IDX) ? '0 : fill_q + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  iwof_ram #(
    .WIDTH (TICK_W),
    .DEPTH (iwof_pkg::WINDOW_LENGTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (fill_q),
    .wdata_i (tick),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  iwof_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cfg_i    (cfg_q),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .busy_o   (busy),
    .done_o   (done),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_select   <= iwof_pkg::MODE_MEDIAN;
      cfg_q.ps_per_tick   <= iwof_pkg::RES_PS_RESET;
      cfg_q.offset_ps     <= '0;
      cfg_q.resolution_ns <= iwof_pkg::RES_NS_RESET;
      fill_q              <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

FILE: design/iwof_checker.sv
// Port-level checker for the interval window outlier filter, bound to the top level.
`default_nettype none
`include "interval_window_outlier_filter_macros.svh"
module iwof_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire iwof_pkg::out_item_t out_item_o,
  input wire logic                pready
);

  `IWOF_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
  `IWOF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_item_o), "result changed while stalled")
  `IWOF_ASSERT_NOW(a_err_value, out_valid_o && out_item_o.count_error,
                   out_item_o.period_value == '1, "count_error without all-ones period")
  `IWOF_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_o,
                    !$rose(out_valid_o), "result right after input transfer")

endmodule

bind interval_window_outlier_filter iwof_checker u_iwof_checker (.*);
`default_nettype wire
